// ----- rtl/trf_pkg.sv -----
// Shared types and byte constants for the telnet receive filter.
`default_nettype none
package trf_pkg;

	localparam logic [7:0] CH_IAC  = 8'd255;
	localparam logic [7:0] CH_DONT = 8'd254;
	localparam logic [7:0] CH_DO   = 8'd253;
	localparam logic [7:0] CH_WONT = 8'd252;
	localparam logic [7:0] CH_WILL = 8'd251;
	localparam logic [7:0] CH_SB   = 8'd250;
	localparam logic [7:0] CH_SE   = 8'd240;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_NUL  = 8'h00;

	localparam logic [1:0] CMD_WILL = 2'd0;
	localparam logic [1:0] CMD_DO   = 2'd2;

	localparam int unsigned MAX_RES = 3;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_EOL   = 2'd1,
		KIND_REPLY = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		ST_DATA   = 5'b00001,
		ST_IAC    = 5'b00010,
		ST_NEGO   = 5'b00100,
		ST_SUB    = 5'b01000,
		ST_SUBIAC = 5'b10000
	} proto_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] value;
	} result_t;

	typedef struct packed {
		logic [1:0]            count;
		result_t [MAX_RES-1:0] res;
	} group_t;

endpackage
`default_nettype wire

// ----- rtl/trf_decode.sv -----
// Protocol state registers and per-byte result decode.
`default_nettype none
module trf_decode
	import trf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] rx_byte,
	output group_t          grp
);

	proto_state_t state_q, state_d;
	logic [1:0]   pend_q, pend_d;
	logic         cr_q, cr_d;
	group_t       app_grp;
	logic         app_cr;

	always_comb begin
		app_grp = '0;
		app_cr  = 1'b0;
		if (cr_q) begin
			app_grp.res[0].kind  = KIND_DATA;
			app_grp.res[0].value = CH_CR;
			app_grp.count        = 2'd1;
			if (rx_byte == CH_LF) begin
				app_grp.res[0].kind  = KIND_EOL;
				app_grp.res[0].value = 8'd0;
			end else if (rx_byte == CH_CR) begin
				app_cr = 1'b1;
			end else if (rx_byte != CH_NUL) begin
				app_grp.res[1].kind  = KIND_DATA;
				app_grp.res[1].value = rx_byte;
				app_grp.count        = 2'd2;
			end
		end else if (rx_byte == CH_CR) begin
			app_cr = 1'b1;
		end else if (rx_byte == CH_LF) begin
			app_grp.res[0].kind  = KIND_EOL;
			app_grp.res[0].value = 8'd0;
			app_grp.count        = 2'd1;
		end else begin
			app_grp.res[0].kind  = KIND_DATA;
			app_grp.res[0].value = rx_byte;
			app_grp.count        = 2'd1;
		end
	end

	always_comb begin
		grp     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		cr_d    = cr_q;
		case (state_q)
			ST_IAC: begin
				state_d = ST_DATA;
				if (rx_byte == CH_IAC) begin
					grp  = app_grp;
					cr_d = app_cr;
				end else if (rx_byte inside {[CH_WILL:CH_DONT]}) begin
					pend_d  = 2'(rx_byte - CH_WILL);
					state_d = ST_NEGO;
				end else if (rx_byte == CH_SB) begin
					state_d = ST_SUB;
				end
			end
			ST_NEGO: begin
				if (pend_q == CMD_DO || pend_q == CMD_WILL) begin
					grp.count        = 2'd3;
					grp.res[0].kind  = KIND_REPLY;
					grp.res[0].value = CH_IAC;
					grp.res[1].kind  = KIND_REPLY;
					grp.res[1].value = (pend_q == CMD_DO) ? CH_WONT : CH_DONT;
					grp.res[2].kind  = KIND_REPLY;
					grp.res[2].value = rx_byte;
				end
				pend_d  = CMD_WILL;
				state_d = ST_DATA;
			end
			ST_SUB: begin
				if (rx_byte == CH_IAC) begin
					state_d = ST_SUBIAC;
				end
			end
			ST_SUBIAC: begin
				state_d = (rx_byte == CH_SE) ? ST_DATA : ST_SUB;
			end
			default: begin
				state_d = ST_DATA;
				if (rx_byte == CH_IAC) begin
					state_d = ST_IAC;
				end else begin
					grp  = app_grp;
					cr_d = app_cr;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			pend_q  <= CMD_WILL;
			cr_q    <= 1'b0;
		end else if (accept) begin
			state_q <= state_d;
			pend_q  <= pend_d;
			cr_q    <= cr_d;
		end
	end

	a_nego_group: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEGO) |-> (grp.count == 2'd0 || grp.count == 2'd3))
		else $error("option byte must give no reply or a full reply");
	a_sub_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB || state_q == ST_SUBIAC) |-> (grp.count == 2'd0))
		else $error("subnegotiation must give no results");
	a_cr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (state_q == ST_SUB || state_q == ST_NEGO)) |=> $stable(cr_q))
		else $error("pending CR must hold across commands");

endmodule
`default_nettype wire

// ----- rtl/trf_out_buf.sv -----
// Result group register that sends one result per request.
`default_nettype none
module trf_out_buf
	import trf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire group_t     grp,
	output logic            free,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic [7:0]      m_tuser,
	output logic            m_tlast
);

	result_t [MAX_RES-1:0] res_q;
	logic [1:0]            cnt_q;
	logic [1:0]            idx_q;
	logic                  take;
	logic                  at_last;

	assign m_tvalid = (cnt_q != 2'd0);
	assign take     = m_tvalid && m_tready;
	assign at_last  = (idx_q == 2'(cnt_q - 2'd1));
	assign free     = (cnt_q == 2'd0) || (take && at_last);
	assign m_tdata  = res_q[idx_q].value;
	assign m_tuser  = {6'd0, res_q[idx_q].kind};
	assign m_tlast  = at_last;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= grp.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= grp.count;
			idx_q <= 2'd0;
		end else if (take && at_last) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q < cnt_q))
		else $error("result index past group count");
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (idx_q == 2'd0 && m_tvalid))
		else $error("loaded group must start at its first result");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("group loaded over unsent results");

endmodule
`default_nettype wire

// ----- rtl/telnet_receive_filter_top.sv -----
// Top level of the telnet receive filter.
// The first result of a byte is registered and offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready stays high.
// A byte that gives two or three results holds the input until the result register
// has sent them, one request at a time.
// Reset: arst_n clears protocol state, pending CR and the result count and index at once; result values are not reset.
`default_nettype none
module telnet_receive_filter_top
	import trf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_value
	output logic [7:0]      m_tuser,   // [1:0] out_kind, [7:2] zero
	output logic            m_tlast    // out_last
);

	group_t grp;
	logic   accept;
	logic   free;

	assign s_tready = free;
	assign accept   = s_tvalid && free;

	trf_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (s_tdata),
		.grp     (grp)
	);

	trf_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && (grp.count != 2'd0)),
		.grp      (grp),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ----- verif/nvt_filter_checker.sv -----
// Checker for the telnet receive filter: predicts results from accepted bytes and compares them.
module nvt_filter_checker
	import trf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	input  wire logic       s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       m_tvalid,
	input  wire logic       m_tready,
	input  wire logic [7:0] m_tdata,
	input  wire logic [7:0] m_tuser,
	input  wire logic       m_tlast,
	output int              fail_count,
	output int              results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		kind_t      kind;
		logic [7:0] value;
		logic       last;
	} nvt_result_t;

	nvt_result_t  owed_q[$];
	proto_state_t nvt_state;
	logic [1:0]   nvt_cmd;
	logic         held_cr;
	int           emitted;

	function automatic void push_result(kind_t k, logic [7:0] v);
		nvt_result_t r;
		r.kind  = k;
		r.value = v;
		r.last  = 1'b0;
		owed_q.push_back(r);
		emitted++;
	endfunction

	function automatic void pass_app_byte(logic [7:0] b);
		if (held_cr) begin
			held_cr = 1'b0;
			if (b == CH_LF) begin
				push_result(KIND_EOL, 8'h00);
				return;
			end
			push_result(KIND_DATA, CH_CR);
			if (b == CH_NUL)
				return;
		end
		if (b == CH_CR)
			held_cr = 1'b1;
		else if (b == CH_LF)
			push_result(KIND_EOL, 8'h00);
		else
			push_result(KIND_DATA, b);
	endfunction

	function automatic void filter_byte(logic [7:0] b);
		emitted = 0;
		case (nvt_state)
		ST_IAC: begin
			if (b == CH_IAC) begin
				pass_app_byte(CH_IAC);
				nvt_state = ST_DATA;
			end else if (b >= CH_WILL && b <= CH_DONT) begin
				nvt_cmd   = b[1:0] - CH_WILL[1:0];
				nvt_state = ST_NEGO;
			end else if (b == CH_SB) begin
				nvt_state = ST_SUB;
			end else begin
				nvt_state = ST_DATA;
			end
		end
		ST_NEGO: begin
			if (nvt_cmd == CMD_DO || nvt_cmd == CMD_WILL) begin
				push_result(KIND_REPLY, CH_IAC);
				push_result(KIND_REPLY, (nvt_cmd == CMD_DO) ? CH_WONT : CH_DONT);
				push_result(KIND_REPLY, b);
			end
			nvt_cmd   = CMD_WILL;
			nvt_state = ST_DATA;
		end
		ST_SUB: begin
			if (b == CH_IAC)
				nvt_state = ST_SUBIAC;
		end
		ST_SUBIAC: begin
			nvt_state = (b == CH_SE) ? ST_DATA : ST_SUB;
		end
		default: begin
			if (b == CH_IAC) begin
				nvt_state = ST_IAC;
			end else begin
				nvt_state = ST_DATA;
				pass_app_byte(b);
			end
		end
		endcase
		if (emitted > 0)
			owed_q[owed_q.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nvt_result_t want;
		if (!arst_n) begin
			nvt_state  = ST_DATA;
			nvt_cmd    = CMD_WILL;
			held_cr    = 1'b0;
			fail_count = 0;
			owed_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected result: out_kind %0d out_value %0d out_last %0d",
						m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (m_tuser !== {6'b0, want.kind}) begin
						$error("out_kind: expected %0d, got %0d", want.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata !== want.value) begin
						$error("out_value: expected %0d, got %0d", want.value, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("out_last: expected %0d, got %0d", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				filter_byte(s_tdata);
		end
		results_owed = owed_q.size();
	end

endmodule

// ----- verif/telnet_receive_filter_top_tb.sv -----
// Testbench top for the telnet receive filter: clock, reset, byte stimulus and verdict.
module telnet_receive_filter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import trf_pkg::*;

	localparam int BYTE_TARGET = 230;
	localparam int QUIET_LIMIT = 2000;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic [7:0] m_tuser;
	logic       m_tlast;
	int         fail_count;
	int         results_owed;
	int         quiet_cycles = 0;
	int         bytes_sent = 0;
	bit         steady_send = 1'b0;
	bit         steady_recv = 1'b0;

	telnet_receive_filter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	nvt_filter_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady_send ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_sent++;
	endtask

	initial begin
		logic [7:0] seg[$];
		int         pick;
		int         body;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		seg = '{CH_LF, CH_CR, CH_NUL, CH_CR, 8'h78, CH_CR, CH_CR, CH_LF, CH_IAC, CH_IAC,
			CH_CR, CH_IAC, CH_DO, CH_NUL, CH_LF, CH_IAC, CH_WILL, CH_IAC,
			CH_IAC, CH_SB, 8'h01, CH_IAC, CH_NUL, CH_IAC, CH_SE};
		foreach (seg[i])
			send_byte(seg[i]);

		// hold until every owed result has drained
		s_tvalid = 1'b0;
		while (results_owed != 0)
			@(negedge clk);

		while (bytes_sent < BYTE_TARGET) begin
			seg.delete();
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				case ($urandom_range(0, 5))
				0: seg.push_back(CH_CR);
				1: seg.push_back(CH_LF);
				2: seg.push_back(CH_NUL);
				default: seg.push_back(8'($urandom_range(0, 254)));
				endcase
			end else if (pick < 45) begin
				seg = '{CH_IAC, CH_IAC};
			end else if (pick < 70) begin
				seg = '{CH_IAC, 8'(CH_WILL + $urandom_range(0, 3)),
					8'($urandom_range(0, 255))};
			end else if (pick < 78) begin
				seg = '{CH_IAC, 8'($urandom_range(CH_SE, CH_SB - 1))};
			end else if (pick < 90) begin
				seg = '{CH_IAC, CH_SB};
				body = $urandom_range(0, 4);
				repeat (body) begin
					if ($urandom_range(0, 4) == 0)
						seg.push_back(CH_IAC);
					else
						seg.push_back(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 5) != 0) begin
					seg.push_back(CH_IAC);
					seg.push_back(CH_SE);
				end
			end else begin
				seg.push_back(8'($urandom_range(0, 255)));
			end
			foreach (seg[i])
				send_byte(seg[i]);
			if ($urandom_range(0, 9) == 0)
				steady_send = !steady_send;
		end

		s_tvalid = 1'b0;
		while (results_owed != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("telnet_receive_filter_top: match");
		else
			$display("telnet_receive_filter_top: mismatch");
		$finish;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			stall = steady_recv ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				steady_recv = !steady_recv;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("telnet_receive_filter_top: mismatch");
				$finish;
			end
		end
	end

endmodule
